### src/sst_pkg.sv
package sst_pkg;

   localparam int SST_TABLE_DEPTH = 64;
   localparam int SST_NAME_BYTES  = 8;

   localparam int CMD_W    = 3;
   localparam int NAME_W   = 64;
   localparam int TYPE_W   = 8;
   localparam int DEPTH_W  = 8;
   localparam int IDX_W    = 6;
   localparam int STATUS_W = 3;
   localparam int RIDX_W   = 6;
   localparam int CNT_W    = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_SCOPE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_OLD  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND_NEW  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd4;

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_PUSH,
      SEL_POP,
      SEL_ENTRY
   } rsp_sel_type;

   typedef struct packed {
      logic                load_req;
      logic                push;
      logic                pop;
      logic                rd_index;
      logic                scan_first;
      logic                scan_next;
      logic                rsp_load;
      rsp_sel_type         rsp_sel;
      logic [STATUS_W-1:0] rsp_status;
   } sst_ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             empty;
      logic             full;
      logic             idx_bad;
      logic             key_hit;
      logic             depth_hit;
      logic             scan_end;
   } sst_stat_type;

endpackage

### src/sst_datapath.sv
module sst_datapath #(
   parameter int TABLE_DEPTH = sst_pkg::SST_TABLE_DEPTH,
   parameter int NAME_BYTES  = sst_pkg::SST_NAME_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sst_pkg::sst_ctrl_type          ctrl_i,
   output sst_pkg::sst_stat_type          stat_o,
   input  logic [sst_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sst_pkg::NAME_W-1:0]     req_name_key,
   input  logic [sst_pkg::TYPE_W-1:0]     req_type_code,
   input  logic                           req_init_flag,
   input  logic [sst_pkg::DEPTH_W-1:0]    req_entry_depth,
   input  logic [sst_pkg::DEPTH_W-1:0]    req_current_depth,
   input  logic [sst_pkg::IDX_W-1:0]      req_entry_index,
   output logic [sst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sst_pkg::RIDX_W-1:0]     rsp_result_index,
   output logic [sst_pkg::CNT_W-1:0]      rsp_entry_count,
   output logic [sst_pkg::NAME_W-1:0]     rsp_out_name_key,
   output logic [sst_pkg::TYPE_W-1:0]     rsp_out_type,
   output logic                           rsp_out_init,
   output logic [sst_pkg::DEPTH_W-1:0]    rsp_out_depth,
   output logic                           rsp_visible,
   output logic                           rsp_same_scope
);
   import sst_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = NAME_BYTES * 8;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   typedef struct packed {
      logic [KW-1:0]      key;
      logic [TYPE_W-1:0]  tcode;
      logic               init;
      logic [DEPTH_W-1:0] depth;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   entry_type wr_data;

   logic [CMD_W-1:0]   cmd_ff;
   logic [KW-1:0]      key_ff;
   logic [TYPE_W-1:0]  type_ff;
   logic               init_ff;
   logic [DEPTH_W-1:0] edepth_ff;
   logic [DEPTH_W-1:0] cur_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic [CW-1:0] count_ff, count_in, count_m1;
   logic [AW-1:0] ptr_ff, ptr_in, top_addr, first_addr, next_addr, idx_addr, wr_addr;
   logic [AW+IDX_W-1:0]   idx_addr_wide;
   logic [CW+IDX_W-1:0]   idx_cmp, cnt_cmp;
   logic [CW+CNT_W-1:0]   count_wide;
   logic [KW+NAME_W-1:0]  key_wide;

   logic [STATUS_W-1:0] status_ff;
   logic [RIDX_W-1:0]   rindex_ff, rindex_in;
   logic [NAME_W-1:0]   okey_ff, okey_in;
   logic [TYPE_W-1:0]   otype_ff, otype_in;
   logic                oinit_ff, oinit_in;
   logic [DEPTH_W-1:0]  odepth_ff, odepth_in;
   logic                vis_ff, vis_in;
   logic                same_ff, same_in;

   function automatic logic [RIDX_W-1:0] to_ridx(input logic [CW-1:0] v);
      logic [CW+RIDX_W-1:0] w;
      w = {{RIDX_W{1'b0}}, v};
      return w[RIDX_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ctrl_i.load_req) begin
         cmd_ff    <= req_cmd;
         key_ff    <= req_name_key[KW-1:0];
         type_ff   <= req_type_code;
         init_ff   <= req_init_flag;
         edepth_ff <= req_entry_depth;
         cur_ff    <= req_current_depth;
         idx_ff    <= req_entry_index;
      end
   end

   assign count_m1      = count_ff - 1'b1;
   assign top_addr      = count_m1[AW-1:0];
   assign wr_addr       = count_ff[AW-1:0];
   assign idx_addr_wide = {{AW{1'b0}}, idx_ff};
   assign idx_addr      = idx_addr_wide[AW-1:0];
   assign first_addr    = (cmd_ff == CMD_FIND_OLD) ? '0 : top_addr;
   assign next_addr     = (cmd_ff == CMD_FIND_OLD) ? ptr_ff + 1'b1 : ptr_ff - 1'b1;

   always_comb begin
      if (ctrl_i.scan_first) begin
         ptr_in = first_addr;
      end else if (ctrl_i.scan_next) begin
         ptr_in = next_addr;
      end else if (ctrl_i.rd_index) begin
         ptr_in = idx_addr;
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_comb begin
      if (ctrl_i.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl_i.pop) begin
         count_in = count_m1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign wr_data = '{key: key_ff, tcode: type_ff, init: init_ff, depth: edepth_ff};

   always_ff @(posedge clock) begin
      if (ctrl_i.push) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ptr_in];
      ptr_ff     <= ptr_in;
   end

   assign idx_cmp = {{CW{1'b0}}, idx_ff};
   assign cnt_cmp = {{IDX_W{1'b0}}, count_ff};

   always_comb begin
      stat_o.cmd       = cmd_ff;
      stat_o.empty     = (count_ff == '0);
      stat_o.full      = (count_ff == FULL_COUNT);
      stat_o.idx_bad   = (idx_cmp >= cnt_cmp);
      stat_o.key_hit   = (rd_data_ff.key == key_ff);
      stat_o.depth_hit = (rd_data_ff.depth == cur_ff);
      stat_o.scan_end  = (cmd_ff == CMD_FIND_OLD) ? (ptr_ff == top_addr) : (ptr_ff == '0);
   end

   assign key_wide = {{NAME_W{1'b0}}, rd_data_ff.key};

   always_comb begin
      rindex_in = '0;
      okey_in   = '0;
      otype_in  = '0;
      oinit_in  = 1'b0;
      odepth_in = '0;
      vis_in    = 1'b0;
      same_in   = 1'b0;
      case (ctrl_i.rsp_sel)
         SEL_PUSH: begin
            rindex_in = to_ridx(count_ff);
         end
         SEL_POP: begin
            rindex_in = to_ridx(count_m1);
         end
         SEL_ENTRY: begin
            rindex_in = to_ridx(CW'(ptr_ff));
            okey_in   = key_wide[NAME_W-1:0];
            otype_in  = rd_data_ff.tcode;
            oinit_in  = rd_data_ff.init;
            odepth_in = rd_data_ff.depth;
            vis_in    = (rd_data_ff.depth <= cur_ff);
            same_in   = (rd_data_ff.depth == cur_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl_i.rsp_load) begin
         status_ff <= ctrl_i.rsp_status;
         rindex_ff <= rindex_in;
         okey_ff   <= okey_in;
         otype_ff  <= otype_in;
         oinit_ff  <= oinit_in;
         odepth_ff <= odepth_in;
         vis_ff    <= vis_in;
         same_ff   <= same_in;
      end
   end

   assign count_wide       = {{CNT_W{1'b0}}, count_ff};
   assign rsp_entry_count  = count_wide[CNT_W-1:0];
   assign rsp_status       = status_ff;
   assign rsp_result_index = rindex_ff;
   assign rsp_out_name_key = okey_ff;
   assign rsp_out_type     = otype_ff;
   assign rsp_out_init     = oinit_ff;
   assign rsp_out_depth    = odepth_ff;
   assign rsp_visible      = vis_ff;
   assign rsp_same_scope   = same_ff;

endmodule

### src/sst_controller.sv
module sst_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sst_pkg::sst_stat_type stat_i,
   output sst_pkg::sst_ctrl_type ctrl_o
);
   import sst_pkg::*;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_SCAN,
      CTL_RDWAIT,
      CTL_RESP
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          req_stall_ff;
   logic          rsp_valid_ff;

   always_comb begin
      state_in          = state_ff;
      ctrl_o            = '0;
      ctrl_o.rsp_sel    = SEL_NONE;
      ctrl_o.rsp_status = STATUS_OK;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               ctrl_o.load_req = 1'b1;
               state_in        = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in = CTL_RESP;
            case (stat_i.cmd)
               CMD_PUSH: begin
                  ctrl_o.rsp_load = 1'b1;
                  if (stat_i.full) begin
                     ctrl_o.rsp_status = STATUS_FULL;
                  end else begin
                     ctrl_o.push    = 1'b1;
                     ctrl_o.rsp_sel = SEL_PUSH;
                  end
               end
               CMD_POP: begin
                  ctrl_o.rsp_load = 1'b1;
                  if (stat_i.empty) begin
                     ctrl_o.rsp_status = STATUS_EMPTY;
                  end else begin
                     ctrl_o.pop     = 1'b1;
                     ctrl_o.rsp_sel = SEL_POP;
                  end
               end
               CMD_POP_SCOPE, CMD_FIND_OLD, CMD_FIND_NEW: begin
                  if (stat_i.empty) begin
                     ctrl_o.rsp_load = 1'b1;
                     if (stat_i.cmd != CMD_POP_SCOPE) begin
                        ctrl_o.rsp_status = STATUS_NOT_FOUND;
                     end
                  end else begin
                     ctrl_o.scan_first = 1'b1;
                     state_in          = CTL_SCAN;
                  end
               end
               CMD_READ: begin
                  if (stat_i.idx_bad) begin
                     ctrl_o.rsp_load   = 1'b1;
                     ctrl_o.rsp_status = STATUS_BAD_INDEX;
                  end else begin
                     ctrl_o.rd_index = 1'b1;
                     state_in        = CTL_RDWAIT;
                  end
               end
               default: begin
                  ctrl_o.rsp_load = 1'b1;
               end
            endcase
         end
         CTL_SCAN: begin
            if (stat_i.cmd == CMD_POP_SCOPE) begin
               if (stat_i.depth_hit) begin
                  ctrl_o.pop = 1'b1;
                  if (stat_i.scan_end) begin
                     ctrl_o.rsp_load = 1'b1;
                     state_in        = CTL_RESP;
                  end else begin
                     ctrl_o.scan_next = 1'b1;
                  end
               end else begin
                  ctrl_o.rsp_load = 1'b1;
                  state_in        = CTL_RESP;
               end
            end else if (stat_i.key_hit) begin
               ctrl_o.rsp_load = 1'b1;
               ctrl_o.rsp_sel  = SEL_ENTRY;
               state_in        = CTL_RESP;
            end else if (stat_i.scan_end) begin
               ctrl_o.rsp_load   = 1'b1;
               ctrl_o.rsp_status = STATUS_NOT_FOUND;
               state_in          = CTL_RESP;
            end else begin
               ctrl_o.scan_next = 1'b1;
            end
         end
         CTL_RDWAIT: begin
            ctrl_o.rsp_load = 1'b1;
            ctrl_o.rsp_sel  = SEL_ENTRY;
            state_in        = CTL_RESP;
         end
         CTL_RESP: begin
            if (!rsp_stall) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != CTL_IDLE);
         rsp_valid_ff <= (state_in == CTL_RESP);
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   a_busy_while_responding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall_ff)
      else $error("Request channel open while a response is pending.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      ctrl_o.push |-> !stat_i.full)
      else $error("Push issued with the table full.");

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall_ff) |=> (state_ff == CTL_EXEC))
      else $error("Accepted transaction did not start execution.");

   a_scan_stops_at_end: assert property (@(posedge clock) disable iff (reset)
      ctrl_o.scan_next |-> !stat_i.scan_end)
      else $error("Scan advanced past the last entry.");

endmodule

### src/scoped_symbol_table_core.sv
// One transaction is handled at a time. Push, pop, pop scope on an empty
// table, reads with a bad index and unknown commands pass from the execute
// state straight to the response state; a read by index also passes a
// read-wait state first. Find oldest, find newest and pop scope walk the
// entry memory through its single registered read port, one entry per cycle,
// and examine entries in the scan state, up to the number of
// stored entries. Entry contents are not cleared at reset; only the entry
// count is, and no entry at or above the count is ever read.
module scoped_symbol_table_core #(
   parameter int TABLE_DEPTH = sst_pkg::SST_TABLE_DEPTH,
   parameter int NAME_BYTES  = sst_pkg::SST_NAME_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sst_pkg::CMD_W-1:0]     req_cmd,
   input  logic [sst_pkg::NAME_W-1:0]    req_name_key,
   input  logic [sst_pkg::TYPE_W-1:0]    req_type_code,
   input  logic                          req_init_flag,
   input  logic [sst_pkg::DEPTH_W-1:0]   req_entry_depth,
   input  logic [sst_pkg::DEPTH_W-1:0]   req_current_depth,
   input  logic [sst_pkg::IDX_W-1:0]     req_entry_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sst_pkg::RIDX_W-1:0]    rsp_result_index,
   output logic [sst_pkg::CNT_W-1:0]     rsp_entry_count,
   output logic [sst_pkg::NAME_W-1:0]    rsp_out_name_key,
   output logic [sst_pkg::TYPE_W-1:0]    rsp_out_type,
   output logic                          rsp_out_init,
   output logic [sst_pkg::DEPTH_W-1:0]   rsp_out_depth,
   output logic                          rsp_visible,
   output logic                          rsp_same_scope
);
   import sst_pkg::*;

   sst_ctrl_type ctrl;
   sst_stat_type stat;

   sst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat_i    (stat),
      .ctrl_o    (ctrl)
   );

   sst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_BYTES  (NAME_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl_i            (ctrl),
      .stat_o            (stat),
      .req_cmd           (req_cmd),
      .req_name_key      (req_name_key),
      .req_type_code     (req_type_code),
      .req_init_flag     (req_init_flag),
      .req_entry_depth   (req_entry_depth),
      .req_current_depth (req_current_depth),
      .req_entry_index   (req_entry_index),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_out_name_key  (rsp_out_name_key),
      .rsp_out_type      (rsp_out_type),
      .rsp_out_init      (rsp_out_init),
      .rsp_out_depth     (rsp_out_depth),
      .rsp_visible       (rsp_visible),
      .rsp_same_scope    (rsp_same_scope)
   );

endmodule
